>>> design/cia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, codes and the control store of the compacting integer array.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W    = 2;
  localparam int POS_W   = 6;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

  localparam int PC_W = 4;

  // step addresses of the control program
  localparam logic [PC_W-1:0] PC_WAIT  = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 4'd1;
  localparam logic [PC_W-1:0] PC_OPSEL = 4'd2;
  localparam logic [PC_W-1:0] PC_CAPT  = 4'd3;
  localparam logic [PC_W-1:0] PC_PRIME = 4'd4;
  localparam logic [PC_W-1:0] PC_MOVE  = 4'd5;
  localparam logic [PC_W-1:0] PC_DEC   = 4'd6;
  localparam logic [PC_W-1:0] PC_EMIT  = 4'd7;
  localparam logic [PC_W-1:0] PC_APP   = 4'd8;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_CHECK,
    ACT_RD,
    ACT_CAPT,
    ACT_PRIME,
    ACT_MOVE,
    ACT_DEC,
    ACT_APP,
    ACT_EMIT
  } act_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NOT_ACC,
    JC_ERR,
    JC_APPEND,
    JC_READ,
    JC_LAST,
    JC_MORE_OR_BUSY
  } jcond_t;

  typedef struct packed {
    logic             in_ready;
    act_t             act;
    jcond_t           jc;
    logic [PC_W-1:0]  jmp;
    logic [PC_W-1:0]  nxt;
  } uword_t;

  typedef struct packed {
    logic acc;
    logic err;
    logic is_app;
    logic is_read;
    logic last;
    logic more;
    logic out_busy;
  } flags_t;

  // control program: jump to jmp when jc holds, otherwise go to nxt
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{in_ready: 1'b0, act: ACT_NOP, jc: JC_ALWAYS, jmp: PC_WAIT, nxt: PC_WAIT};
    unique case (pc)
      PC_WAIT:  w = '{1'b1, ACT_LOAD,  JC_NOT_ACC,      PC_WAIT, PC_CHECK};
      PC_CHECK: w = '{1'b0, ACT_CHECK, JC_ERR,          PC_EMIT, PC_OPSEL};
      PC_OPSEL: w = '{1'b0, ACT_RD,    JC_APPEND,       PC_APP,  PC_CAPT};
      PC_CAPT:  w = '{1'b0, ACT_CAPT,  JC_READ,         PC_EMIT, PC_PRIME};
      PC_PRIME: w = '{1'b0, ACT_PRIME, JC_LAST,         PC_DEC,  PC_MOVE};
      PC_MOVE:  w = '{1'b0, ACT_MOVE,  JC_MORE_OR_BUSY, PC_MOVE, PC_DEC};
      PC_DEC:   w = '{1'b0, ACT_DEC,   JC_ALWAYS,       PC_EMIT, PC_EMIT};
      PC_EMIT:  w = '{1'b0, ACT_EMIT,  JC_MORE_OR_BUSY, PC_EMIT, PC_WAIT};
      PC_APP:   w = '{1'b0, ACT_APP,   JC_ALWAYS,       PC_EMIT, PC_EMIT};
      default:  w = '{1'b0, ACT_NOP,   JC_ALWAYS,       PC_WAIT, PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

>>> design/cia_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_seq
// Step counter and control store; picks the next step from datapath flags.
// ----------------------------------------------------------------------------
module cia_seq
  import cia_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output uword_t ctrl
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign ctrl = ucode(pc_r);

  always_comb begin
    unique case (ctrl.jc)
      JC_NEVER:        take = 1'b0;
      JC_ALWAYS:       take = 1'b1;
      JC_NOT_ACC:      take = !flags.acc;
      JC_ERR:          take = flags.err;
      JC_APPEND:       take = flags.is_app;
      JC_READ:         take = flags.is_read;
      JC_LAST:         take = flags.last;
      // shared code: MOVE loops on more, EMIT holds while the output is full
      JC_MORE_OR_BUSY: take = (ctrl.act == ACT_MOVE) ? flags.more : flags.out_busy;
      default:         take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.jmp : ctrl.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> design/cia_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_dp
// Entry store, count, address register and result register.
// ----------------------------------------------------------------------------
module cia_dp
  import cia_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  uword_t              ctrl,
  output flags_t              flags,
  input  logic                in_valid,
  input  logic [OP_W-1:0]     in_op,
  input  logic [POS_W-1:0]    in_pos,
  input  logic [VAL_W-1:0]    in_val,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VAL_W-1:0]    out_data,
  output logic [ST_W-1:0]     out_status,
  output logic [COUNT_W-1:0]  out_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [VAL_W-1:0] mem [CAPACITY];

  logic [OP_W-1:0]    op_r;
  logic [POS_W-1:0]   pos_r;
  logic [VAL_W-1:0]   val_r;
  logic [CW-1:0]      used_r, used_nxt;
  logic [AW-1:0]      addr_r, addr_nxt;
  logic [VAL_W-1:0]   data_r, data_nxt;
  logic [ST_W-1:0]    status_r, status_nxt;
  logic [VAL_W-1:0]   rd_data_r;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VAL_W-1:0]   wr_data;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_data_r;
  logic [ST_W-1:0]    out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [PW-1:0]      pos_ext, used_ext;
  logic [CW:0]        addr_w, used_w;
  logic [CW+COUNT_W-1:0] count_ext;
  logic               full, bad, op_ok, emit;

  always_comb begin
    pos_ext  = PW'(pos_r);
    used_ext = PW'(used_r);
    addr_w   = (CW+1)'(addr_r);
    used_w   = (CW+1)'(used_r);
    full     = (used_r == CW'(CAPACITY));
    op_ok    = (op_r == OP_REMOVE) || (op_r == OP_READ);
    bad      = !op_ok || (pos_ext >= used_ext);

    flags.acc      = in_valid && ctrl.in_ready;
    flags.is_app   = (op_r == OP_APPEND);
    flags.is_read  = (op_r == OP_READ);
    flags.err      = flags.is_app ? full : bad;
    flags.last     = (addr_w + (CW+1)'(1)) >= used_w;
    flags.more     = (addr_w + (CW+1)'(2)) < used_w;
    flags.out_busy = out_valid_r && !out_ready;
    emit           = (ctrl.act == ACT_EMIT) && !flags.out_busy;
  end

  always_comb begin
    used_nxt   = used_r;
    addr_nxt   = addr_r;
    data_nxt   = data_r;
    status_nxt = status_r;
    rd_addr    = addr_r;
    wr_en      = 1'b0;
    wr_addr    = addr_r;
    wr_data    = rd_data_r;
    unique case (ctrl.act)
      ACT_CHECK: begin
        data_nxt   = '0;
        addr_nxt   = pos_ext[AW-1:0];
        status_nxt = flags.err ? (flags.is_app ? ST_FULL : ST_BAD) : ST_OK;
      end
      ACT_CAPT:  data_nxt = rd_data_r;
      ACT_PRIME: rd_addr  = AW'(addr_w + (CW+1)'(1));
      ACT_MOVE: begin
        // rd_data_r holds the entry one place above addr_r
        wr_en    = 1'b1;
        addr_nxt = AW'(addr_w + (CW+1)'(1));
        rd_addr  = AW'(addr_w + (CW+1)'(2));
      end
      ACT_DEC: used_nxt = used_r - CW'(1);
      ACT_APP: begin
        wr_en    = 1'b1;
        wr_addr  = AW'(used_r);
        wr_data  = val_r;
        used_nxt = used_r + CW'(1);
      end
      ACT_NOP, ACT_LOAD, ACT_RD, ACT_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (flags.acc) begin
      op_r  <= in_op;
      pos_r <= in_pos;
      val_r <= in_val;
    end
    addr_r   <= addr_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign count_ext = (CW+COUNT_W)'(used_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r   <= data_r;
      out_status_r <= status_r;
      out_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;

endmodule

>>> design/compacting_integer_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_integer_array
// Ordered list of signed 32-bit integers: append, remove-at with compaction,
// and read-at, run by a small control program over an entry store.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                    | tuser
// in_     | in  | position[5:0], value[37:6], pad        | op[1:0]
// out_    | out | data[31:0], count[38:32], pad          | status[1:0]
//
// Remove-at moves the entries above the position down one place, one entry moved
// per cycle by the store's single write port. An item is taken only in the wait
// step. Reset clears the count and the result valid; entries need no clearing.
// A held result stalls only the final step; the next item is still taken.
// ----------------------------------------------------------------------------
module compacting_integer_array
  import cia_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // position[5:0], value[37:6], zero pad
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data[31:0], count[38:32], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  uword_t              ctrl;
  flags_t              flags;
  logic [VAL_W-1:0]    out_data;
  logic [ST_W-1:0]     out_status;
  logic [COUNT_W-1:0]  out_count;

  cia_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  cia_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .in_valid   (in_tvalid),
    .in_op      (in_tuser),
    .in_pos     (in_tdata[POS_W-1:0]),
    .in_val     (in_tdata[POS_W+VAL_W-1:POS_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_data),
    .out_status (out_status),
    .out_count  (out_count)
  );

  assign in_tready = ctrl.in_ready;
  assign out_tdata = {1'b0, out_count, out_data};
  assign out_tuser = out_status;

endmodule

>>> design/cia_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_chk
// Port-level checks for the compacting integer array, bound to the top level.
// ----------------------------------------------------------------------------
module cia_chk
  import cia_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [39:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[VAL_W-1:0] == '0))
    else $error("error result carries data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind compacting_integer_array cia_chk u_chk (.*);

>>> tb/tb_compacting_integer_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_compacting_integer_array
// Self-checking bench for the compacting integer array. Directed and random
// append, remove-at and read-at items are checked against an in-bench list
// that tracks the entries and the count, under random sender bursts and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb_compacting_integer_array;
  import cia_pkg::*;

  localparam int LIST_DEPTH   = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 560;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;

  // op code the block does not define; must come back as a bad position
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [VAL_W-1:0]   data;
    logic [ST_W-1:0]    status;
    logic [COUNT_W-1:0] count;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // position[5:0], value[37:6], zero pad
  logic [1:0]  in_tuser = '0;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // data[31:0], count[38:32], zero pad
  logic [1:0]  out_tuser;       // status[1:0]

  list_result_t     pending_results[$];
  logic [VAL_W-1:0] list_mem [LIST_DEPTH];
  int               list_len = 0;

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int n_full = 0;
  int n_bad = 0;
  int n_removed = 0;
  int cycles = 0;

  compacting_integer_array DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // applies one op to the bench copy of the list and returns its result
  function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
                                              input logic [POS_W-1:0] pos,
                                              input logic [VAL_W-1:0] val);
    list_result_t r;
    r.data   = '0;
    r.status = ST_OK;
    case (op)
      OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_REMOVE, OP_READ: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_BAD;
        end else begin
          r.data = list_mem[pos];
          if (op == OP_REMOVE) begin
            for (int i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
            list_len--;
          end
        end
      end
      default: r.status = ST_BAD;
    endcase
    r.count = list_len[COUNT_W-1:0];
    return r;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [VAL_W-1:0] val);
    list_result_t r;
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {2'b00, val, pos};
    do @(posedge clk); while (!in_tready);
    r = list_apply(op, pos, val);
    pending_results.push_back(r);
    items_sent++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_BAD) n_bad++;
    if (op == OP_REMOVE && r.status == ST_OK) n_removed++;
    @(negedge clk);
  endtask

  task automatic test_empty_list();
    send_item(OP_READ, 6'd0, 32'd0);
    send_item(OP_REMOVE, 6'd0, 32'd0);
    send_item(OP_READ, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 6'd63, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 6'd63, 32'hFFFF_FFFF);
  endtask

  task automatic test_append_extremes();
    send_item(OP_APPEND, 6'd0, 32'h8000_0000);
    send_item(OP_APPEND, 6'd63, 32'h7FFF_FFFF);
    send_item(OP_APPEND, 6'd21, 32'h0000_0000);
    send_item(OP_APPEND, 6'd42, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 6'd0, 32'hA5A5_5A5A);
    send_item(OP_READ, 6'd0, 32'd0);
    send_item(OP_READ, 6'd4, 32'd0);
    send_item(OP_READ, 6'd5, 32'd0);        // one past the end
    send_item(OP_REMOVE, 6'd2, 32'd0);      // middle, shifts two entries
    send_item(OP_REMOVE, 6'd3, 32'd0);      // last entry, nothing to shift
    send_item(OP_REMOVE, 6'd0, 32'd0);
    send_item(OP_READ, 6'd0, 32'd0);
    send_item(OP_UNUSED, 6'd0, 32'h1234_5678);
    send_item(OP_READ, 6'd63, 32'd0);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH) send_item(OP_APPEND, 6'($urandom), $urandom);
    send_item(OP_APPEND, 6'd0, 32'hDEAD_BEEF);   // rejected as full
    send_item(OP_READ, 6'd63, 32'd0);
    send_item(OP_REMOVE, 6'd0, 32'd0);           // longest compaction
    send_item(OP_READ, 6'd63, 32'd0);            // now past the end
    send_item(OP_APPEND, 6'd0, 32'h0BAD_F00D);
    send_item(OP_REMOVE, 6'd63, 32'd0);
    send_item(OP_REMOVE, 6'd62, 32'd0);
  endtask

  // alternating fill and drain phases so both full and empty lists recur
  task automatic test_random_mix();
    int               phase_left;
    bit               filling;
    int               burst_left;
    int               pick;
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    phase_left = 0;
    filling    = 1'b0;
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(40, 150);
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_UNUSED;
      else if (pick < (filling ? 85 : 20)) op = OP_APPEND;
      else if ($urandom_range(0, 1) == 1) op = OP_REMOVE;
      else op = OP_READ;
      if (list_len > 0 && $urandom_range(0, 99) < 85)
        pos = POS_W'($urandom_range(0, list_len - 1));
      else pos = POS_W'($urandom_range(0, 63));
      case ($urandom_range(0, 9))
        0: val = 32'h8000_0000;
        1: val = 32'h7FFF_FFFF;
        2: val = '0;
        3: val = '1;
        default: val = $urandom;
      endcase
      send_item(op, pos, val);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid = 1'b0;
          repeat ($urandom_range(1, 8)) @(negedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    in_tvalid = 1'b0;
  endtask

  // receiver stall patterns, each held for a random stretch
  initial begin
    int mode;
    int span;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          2: out_tready = ($urandom_range(0, 7) == 0);
          default: out_tready = (k % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: data=%h count=%0d status=%0d",
                 $time, out_tdata[31:0], out_tdata[38:32], out_tuser);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.data) begin
          errors++;
          $display("%0t: data mismatch: expected %h, actual %h",
                   $time, want.data, out_tdata[31:0]);
        end
        if (out_tdata[38:32] !== want.count) begin
          errors++;
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, out_tdata[38:32]);
        end
        if (out_tuser !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_list();
    test_append_extremes();
    test_full_list();
    test_random_mix();

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end

    $display("Covered %0d items, %0d results checked: %0d removes, %0d full, %0d bad.",
             items_sent, results_seen, n_removed, n_full, n_bad);
    $display("Sender bursts and receiver stalls were random; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
